FILE: src/amd_pkg.sv
// Shared types and constants for the acceleration motion detector.
package amd_pkg;

  localparam int BASELINE_SAMPLES = 20;

  localparam int ACCEL_W = 16;
  localparam int MAG_W   = 16;
  localparam int SUM_W   = 24;
  localparam int CNT_W   = 8;
  localparam int FILT_W  = 24;
  localparam int DIV_SHIFT = 24;
  localparam int MUL_A_W = DIV_SHIFT + 1;
  localparam int MUL_B_W = 24;
  localparam int ACC_W   = MUL_A_W + MUL_B_W;
  localparam int ROOT_W  = 32;
  localparam int ROOT_STEPS = ROOT_W / 2;
  localparam int STEP_W  = $clog2(ROOT_STEPS);

  localparam logic [MUL_A_W-1:0] DIV_MULT = MUL_A_W'((64'd1 << DIV_SHIFT) / BASELINE_SAMPLES);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT   = 2'd2;

  localparam logic [15:0] DEADBAND_RST = 16'd328;
  localparam logic [7:0]  CONFIRM_RST  = 8'd2;
  localparam logic [8:0]  WEIGHT_RST   = 9'd192;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQX,
    OP_SQY,
    OP_SQZ,
    OP_RINIT,
    OP_ROOT,
    OP_EVAL,
    OP_MULF,
    OP_MULC,
    OP_DIVM,
    OP_DIVF,
    OP_COMMIT
  } amd_op_e;

  typedef struct packed {
    amd_op_e op;
  } amd_cmd_t;

  typedef struct packed {
    logic root_last;
    logic bl_done;
    logic bl_last;
    logic out_blocked;
  } amd_status_t;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_SQX   = 11'b000_0000_0010,
    ST_SQY   = 11'b000_0000_0100,
    ST_SQZ   = 11'b000_0000_1000,
    ST_RINIT = 11'b000_0001_0000,
    ST_ROOT  = 11'b000_0010_0000,
    ST_EVAL  = 11'b000_0100_0000,
    ST_MULF  = 11'b000_1000_0000,
    ST_MULC  = 11'b001_0000_0000,
    ST_DIVM  = 11'b010_0000_0000,
    ST_DIVF  = 11'b100_0000_0000
  } amd_state_e;

endpackage

FILE: src/amd_ctrl.sv
// Sequencing state machine of the acceleration motion detector.
module amd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  amd_pkg::amd_status_t  status_i,
  output amd_pkg::amd_cmd_t     cmd_o
);

  amd_pkg::amd_state_e state_q, state_d;
  logic done_q, done_d;

  assign in_stall_o = (state_q != amd_pkg::ST_IDLE) || done_q;

  always_comb begin
    state_d   = state_q;
    done_d    = done_q;
    cmd_o.op  = amd_pkg::OP_NONE;
    if (done_q) begin
      if (!status_i.out_blocked) begin
        cmd_o.op = amd_pkg::OP_COMMIT;
        done_d   = 1'b0;
      end
    end else begin
      case (state_q)
        amd_pkg::ST_IDLE: begin
          if (in_valid_i) begin
            cmd_o.op = amd_pkg::OP_LOAD;
            state_d  = amd_pkg::ST_SQX;
          end
        end
        amd_pkg::ST_SQX: begin
          cmd_o.op = amd_pkg::OP_SQX;
          state_d  = amd_pkg::ST_SQY;
        end
        amd_pkg::ST_SQY: begin
          cmd_o.op = amd_pkg::OP_SQY;
          state_d  = amd_pkg::ST_SQZ;
        end
        amd_pkg::ST_SQZ: begin
          cmd_o.op = amd_pkg::OP_SQZ;
          state_d  = amd_pkg::ST_RINIT;
        end
        amd_pkg::ST_RINIT: begin
          cmd_o.op = amd_pkg::OP_RINIT;
          state_d  = amd_pkg::ST_ROOT;
        end
        amd_pkg::ST_ROOT: begin
          cmd_o.op = amd_pkg::OP_ROOT;
          if (status_i.root_last) begin
            state_d = amd_pkg::ST_EVAL;
          end
        end
        amd_pkg::ST_EVAL: begin
          cmd_o.op = amd_pkg::OP_EVAL;
          if (status_i.bl_done) begin
            state_d = amd_pkg::ST_MULF;
          end else if (status_i.bl_last) begin
            state_d = amd_pkg::ST_DIVM;
          end else begin
            state_d = amd_pkg::ST_IDLE;
            done_d  = 1'b1;
          end
        end
        amd_pkg::ST_MULF: begin
          cmd_o.op = amd_pkg::OP_MULF;
          state_d  = amd_pkg::ST_MULC;
        end
        amd_pkg::ST_MULC: begin
          cmd_o.op = amd_pkg::OP_MULC;
          state_d  = amd_pkg::ST_IDLE;
          done_d   = 1'b1;
        end
        amd_pkg::ST_DIVM: begin
          cmd_o.op = amd_pkg::OP_DIVM;
          state_d  = amd_pkg::ST_DIVF;
        end
        amd_pkg::ST_DIVF: begin
          cmd_o.op = amd_pkg::OP_DIVF;
          state_d  = amd_pkg::ST_IDLE;
          done_d   = 1'b1;
        end
        default: begin
          state_d = amd_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amd_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

endmodule

FILE: src/amd_dp.sv
// Datapath of the acceleration motion detector: multiplier, square root, filter and state.
module amd_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  amd_pkg::amd_cmd_t                    cmd_i,
  output amd_pkg::amd_status_t                 status_o,
  input  logic signed [amd_pkg::ACCEL_W-1:0]   accel_x_i,
  input  logic signed [amd_pkg::ACCEL_W-1:0]   accel_y_i,
  input  logic signed [amd_pkg::ACCEL_W-1:0]   accel_z_i,
  input  logic                                 cfg_we_i,
  input  logic [amd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [amd_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [amd_pkg::MAG_W-1:0]            change_level_o,
  output logic                                 motion_active_o,
  output logic                                 baseline_valid_o
);

  localparam int MW = amd_pkg::MAG_W;

  logic [15:0] deadband_q;
  logic [7:0]  confirm_q;
  logic [8:0]  weight_q;

  logic [MW-1:0] ax_q, ay_q, az_q;
  logic [amd_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [amd_pkg::ROOT_W-1:0] rn_q, rn_d, root_q, root_d, rbit_q, rbit_d;
  logic [amd_pkg::STEP_W-1:0] step_q, step_d;

  logic [amd_pkg::SUM_W-1:0]  sum_q;
  logic [amd_pkg::CNT_W-1:0]  count_q;
  logic                       bl_done_q;
  logic [MW-1:0]              baseline_q;
  logic                       started_q;
  logic [amd_pkg::FILT_W-1:0] filt_q;
  logic [7:0]                 run_q;
  logic                       motion_q;
  logic                       post_q;
  logic [MW-1:0]              change_q;

  logic                       out_valid_q;
  logic [MW-1:0]              level_q;
  logic                       motion_out_q;
  logic                       bv_out_q;

  localparam int MUL_A_W_L = amd_pkg::MUL_A_W;
  logic [MUL_A_W_L-1:0] mul_a;
  logic [amd_pkg::MUL_B_W-1:0] mul_b;
  logic [amd_pkg::ACC_W-1:0]   product;
  logic                        acc_keep;

  logic [8:0] w_sat;
  logic [7:0] need;
  logic [MW-1:0] mag, change;
  logic [8:0] run_inc;
  logic [7:0] run_new;
  logic       above;
  logic [amd_pkg::CNT_W-1:0] count_inc;
  logic [amd_pkg::ROOT_W-1:0] trial;

  logic [amd_pkg::ACC_W-1:0]  acc_round;
  logic [amd_pkg::FILT_W-1:0] filt_new;
  logic                       release_m;
  logic                       motion_new;

  logic [amd_pkg::MUL_A_W-1:0] q0;
  logic [amd_pkg::SUM_W-1:0]   rem;
  logic [amd_pkg::SUM_W-1:0]   quot;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    abs16 = v[15] ? (~v + 16'd1) : v;
  endfunction

  assign w_sat     = (weight_q > 9'd256) ? 9'd256 : weight_q;
  assign need      = (confirm_q == 8'd0) ? 8'd1 : confirm_q;
  assign mag       = root_q[MW-1:0];
  assign change    = (mag >= baseline_q) ? (mag - baseline_q) : (baseline_q - mag);
  assign above     = (change >= deadband_q);
  assign run_inc   = {1'b0, run_q} + 9'd1;
  assign run_new   = (run_inc < {1'b0, need}) ? run_inc[7:0] : need;
  assign count_inc = count_q + 8'd1;
  assign trial     = root_q + rbit_q;

  assign acc_round = acc_q + amd_pkg::ACC_W'(128);
  assign filt_new  = started_q ? acc_round[amd_pkg::FILT_W+7:8] : {change_q, 8'd0};
  assign release_m = motion_q && (change_q < deadband_q) && (filt_new < {deadband_q, 8'd0});
  assign motion_new = motion_q && !release_m;

  assign q0   = acc_q[amd_pkg::ACC_W-1:amd_pkg::DIV_SHIFT];
  assign rem  = sum_q - amd_pkg::SUM_W'(q0[amd_pkg::SUM_W-1:0] *
                amd_pkg::SUM_W'(amd_pkg::BASELINE_SAMPLES));
  assign quot = (rem >= amd_pkg::SUM_W'(amd_pkg::BASELINE_SAMPLES)) ?
                (q0[amd_pkg::SUM_W-1:0] + amd_pkg::SUM_W'(1)) : q0[amd_pkg::SUM_W-1:0];

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    acc_keep = 1'b0;
    case (cmd_i.op)
      amd_pkg::OP_SQX: begin
        mul_a = amd_pkg::MUL_A_W'(ax_q);
        mul_b = amd_pkg::MUL_B_W'(ax_q);
      end
      amd_pkg::OP_SQY: begin
        mul_a    = amd_pkg::MUL_A_W'(ay_q);
        mul_b    = amd_pkg::MUL_B_W'(ay_q);
        acc_keep = 1'b1;
      end
      amd_pkg::OP_SQZ: begin
        mul_a    = amd_pkg::MUL_A_W'(az_q);
        mul_b    = amd_pkg::MUL_B_W'(az_q);
        acc_keep = 1'b1;
      end
      amd_pkg::OP_MULF: begin
        mul_a = amd_pkg::MUL_A_W'(w_sat);
        mul_b = filt_q;
      end
      amd_pkg::OP_MULC: begin
        mul_a    = amd_pkg::MUL_A_W'(9'd256 - w_sat);
        mul_b    = {change_q, 8'd0};
        acc_keep = 1'b1;
      end
      amd_pkg::OP_DIVM: begin
        mul_a = amd_pkg::DIV_MULT;
        mul_b = sum_q;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;
  assign acc_d   = (acc_keep ? acc_q : '0) + product;

  always_comb begin
    rn_d   = rn_q;
    root_d = root_q;
    rbit_d = rbit_q;
    step_d = step_q;
    if (cmd_i.op == amd_pkg::OP_RINIT) begin
      rn_d   = acc_q[amd_pkg::ROOT_W-1:0];
      root_d = '0;
      rbit_d = amd_pkg::ROOT_W'(1) << (amd_pkg::ROOT_W - 2);
      step_d = '0;
    end else if (cmd_i.op == amd_pkg::OP_ROOT) begin
      if (rn_q >= trial) begin
        rn_d   = rn_q - trial;
        root_d = (root_q >> 1) + rbit_q;
      end else begin
        root_d = root_q >> 1;
      end
      rbit_d = rbit_q >> 2;
      step_d = step_q + amd_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    rn_q   <= rn_d;
    root_q <= root_d;
    rbit_q <= rbit_d;
    step_q <= step_d;
    if (cmd_i.op == amd_pkg::OP_LOAD) begin
      ax_q <= abs16(accel_x_i);
      ay_q <= abs16(accel_y_i);
      az_q <= abs16(accel_z_i);
    end
    if (cmd_i.op == amd_pkg::OP_SQX || cmd_i.op == amd_pkg::OP_SQY ||
        cmd_i.op == amd_pkg::OP_SQZ || cmd_i.op == amd_pkg::OP_MULF ||
        cmd_i.op == amd_pkg::OP_MULC || cmd_i.op == amd_pkg::OP_DIVM) begin
      acc_q <= acc_d;
    end
    if (cmd_i.op == amd_pkg::OP_EVAL) begin
      change_q <= change;
    end
    if (cmd_i.op == amd_pkg::OP_COMMIT) begin
      level_q      <= (post_q && motion_new) ? filt_new[amd_pkg::FILT_W-1:8] : '0;
      motion_out_q <= post_q ? motion_new : motion_q;
      bv_out_q     <= bl_done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q  <= amd_pkg::DEADBAND_RST;
      confirm_q   <= amd_pkg::CONFIRM_RST;
      weight_q    <= amd_pkg::WEIGHT_RST;
      sum_q       <= '0;
      count_q     <= '0;
      bl_done_q   <= 1'b0;
      baseline_q  <= '0;
      started_q   <= 1'b0;
      filt_q      <= '0;
      run_q       <= '0;
      motion_q    <= 1'b0;
      post_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          amd_pkg::CFG_DEADBAND: deadband_q <= cfg_data_i;
          amd_pkg::CFG_CONFIRM:  confirm_q  <= cfg_data_i[7:0];
          amd_pkg::CFG_WEIGHT:   weight_q   <= cfg_data_i[8:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.op == amd_pkg::OP_EVAL) begin
        post_q <= bl_done_q;
        if (bl_done_q) begin
          run_q    <= above ? run_new : 8'd0;
          motion_q <= motion_q || (above && (run_new >= need));
        end else begin
          sum_q   <= sum_q + amd_pkg::SUM_W'(mag);
          count_q <= count_inc;
        end
      end
      if (cmd_i.op == amd_pkg::OP_DIVF) begin
        baseline_q <= quot[MW-1:0];
        bl_done_q  <= 1'b1;
      end
      if (cmd_i.op == amd_pkg::OP_COMMIT) begin
        if (post_q) begin
          filt_q    <= filt_new;
          started_q <= 1'b1;
          motion_q  <= motion_new;
        end
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.root_last   = (step_q == amd_pkg::STEP_W'(amd_pkg::ROOT_STEPS - 1));
  assign status_o.bl_done     = bl_done_q;
  assign status_o.bl_last     = (count_inc == amd_pkg::CNT_W'(amd_pkg::BASELINE_SAMPLES));
  assign status_o.out_blocked = out_valid_q && out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign change_level_o   = level_q;
  assign motion_active_o  = motion_out_q;
  assign baseline_valid_o = bv_out_q;

endmodule

FILE: src/acceleration_motion_detector.sv
// Top level of the acceleration motion detector.
// Each accepted sample passes through the load, the three squares, the 16-step iterative
// square root and the evaluation, then the two filter products once the baseline exists,
// or the baseline division for the sample that completes it, before its result is
// registered. The single shared multiplier forms the three squares, the filter products
// and the baseline division; the next sample is taken the cycle after the result is
// registered, unless an earlier result still waits in the output register.
module acceleration_motion_detector (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [amd_pkg::ACCEL_W-1:0]   accel_x_i,
  input  logic signed [amd_pkg::ACCEL_W-1:0]   accel_y_i,
  input  logic signed [amd_pkg::ACCEL_W-1:0]   accel_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [amd_pkg::MAG_W-1:0]            change_level_o,
  output logic                                 motion_active_o,
  output logic                                 baseline_valid_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [amd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [amd_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  amd_pkg::amd_cmd_t    cmd;
  amd_pkg::amd_status_t status;

  assign cfg_ready_o = 1'b1;

  amd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  amd_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .accel_x_i        (accel_x_i),
    .accel_y_i        (accel_y_i),
    .accel_z_i        (accel_z_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .change_level_o   (change_level_o),
    .motion_active_o  (motion_active_o),
    .baseline_valid_o (baseline_valid_o)
  );

endmodule

FILE: src/amd_checker.sv
// Port-level assertions for the acceleration motion detector and their bind.
module amd_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [amd_pkg::MAG_W-1:0]            change_level_o,
  input logic                                 motion_active_o,
  input logic                                 baseline_valid_o
);

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // After a sample is taken the block is busy with it.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second sample taken while busy");

  // Without confirmed motion the change level is zero.
  a_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !motion_active_o |-> change_level_o == '0)
    else $error("nonzero change level without motion");

  // Motion is only confirmed once a baseline exists.
  a_motion_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motion_active_o |-> baseline_valid_o)
    else $error("motion reported before baseline");

endmodule

bind acceleration_motion_detector amd_checker u_amd_checker (.*);

FILE: sim/testbench.sv
// Self-checking testbench for the acceleration motion detector with a built-in predictor.
module testbench;
  import amd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_ITEMS = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] x;
    logic signed [ACCEL_W-1:0] y;
    logic signed [ACCEL_W-1:0] z;
  } accel_sample_t;

  typedef struct packed {
    logic [MAG_W-1:0] level;
    logic             motion;
    logic             ready;
  } detector_result_t;

  typedef struct packed {
    accel_sample_t    sample;
    logic             typed;
    detector_result_t result;
  } directed_row_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] band;
    logic [CFG_DATA_W-1:0] confirm;
    logic [CFG_DATA_W-1:0] weight;
  } phase_setting_t;

  typedef enum logic [1:0] {SHAPE_QUIET, SHAPE_MOVE, SHAPE_EDGE, SHAPE_NOISE} sample_shape_e;

  localparam detector_result_t IDLE_RES = '{16'd0, 1'b0, 1'b0};
  localparam detector_result_t READY_RES = '{16'd0, 1'b0, 1'b1};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [ACCEL_W-1:0] accel_x = '0;
  logic signed [ACCEL_W-1:0] accel_y = '0;
  logic signed [ACCEL_W-1:0] accel_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [MAG_W-1:0] change_level;
  logic motion_active;
  logic baseline_valid;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEADBAND;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [15:0] thresh = DEADBAND_RST;
  logic [7:0]  confirm_need = CONFIRM_RST;
  logic [8:0]  old_weight = WEIGHT_RST;
  logic [23:0] rest_sum = '0;
  logic [7:0]  rest_count = '0;
  logic        rest_ready = 1'b0;
  logic [15:0] rest_level = '0;
  logic        smooth_primed = 1'b0;
  logic [23:0] smooth_level = '0;
  logic [7:0]  above_run = '0;
  logic        moving = 1'b0;

  detector_result_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  logic calm = 1'b0;
  logic hold_request = 1'b0;

  directed_row_t directed_rows [0:24] = '{
    '{'{16'sh8000, 16'sh8000, 16'sh8000}, 1'b1, IDLE_RES},
    '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b1, IDLE_RES},
    '{'{16'sh0000, 16'sh0000, 16'sh0000}, 1'b1, IDLE_RES},
    '{'{16'sh8000, 16'sh0000, 16'sh0000}, 1'b1, IDLE_RES},
    '{'{16'sh0000, 16'sh7FFF, 16'sh0000}, 1'b1, IDLE_RES},
    '{'{16'sh0000, 16'sh0000, 16'sh8000}, 1'b1, IDLE_RES},
    '{'{16'shFFFF, 16'shFFFF, 16'shFFFF}, 1'b1, IDLE_RES},
    '{'{16'sh0001, 16'sh0000, 16'sh0000}, 1'b1, IDLE_RES},
    '{'{16'sh0000, 16'sh0000, 16'sh4000}, 1'b1, IDLE_RES},
    '{'{16'sh0000, 16'sh0000, 16'sh4000}, 1'b1, IDLE_RES},
    '{'{16'sh0000, 16'shC000, 16'sh0000}, 1'b1, IDLE_RES},
    '{'{16'sh4000, 16'sh0000, 16'sh0000}, 1'b1, IDLE_RES},
    '{'{16'sh0000, 16'sh0000, 16'sh4000}, 1'b1, IDLE_RES},
    '{'{16'sh0000, 16'sh0000, 16'sh4000}, 1'b1, IDLE_RES},
    '{'{16'sh0000, 16'sh0000, 16'shC000}, 1'b1, IDLE_RES},
    '{'{16'sh0000, 16'sh0000, 16'sh4000}, 1'b1, IDLE_RES},
    '{'{16'sh0000, 16'sh0000, 16'sh4000}, 1'b1, IDLE_RES},
    '{'{16'sh0000, 16'sh0000, 16'sh4000}, 1'b1, IDLE_RES},
    '{'{16'sh0000, 16'sh0000, 16'sh4000}, 1'b1, IDLE_RES},
    '{'{16'sh0000, 16'sh0000, 16'sh4000}, 1'b1, READY_RES},
    '{'{16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, IDLE_RES},
    '{'{16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, IDLE_RES},
    '{'{16'sh7FFF, 16'sh0000, 16'sh0000}, 1'b0, IDLE_RES},
    '{'{16'sh0000, 16'sh0000, 16'sh52F8}, 1'b0, IDLE_RES},
    '{'{16'sh0000, 16'sh0000, 16'sh52F8}, 1'b0, IDLE_RES}
  };

  phase_setting_t phases [0:6] = '{
    '{16'd0,     16'd0,     16'd0},
    '{16'hFFFF,  16'd255,   16'd256},
    '{16'd50,    16'hFF01,  16'hFFFF},
    '{16'd1000,  16'd5,     16'd128},
    '{16'd328,   16'd2,     16'd257},
    '{16'd0,     16'd0,     16'd0},
    '{16'd0,     16'd0,     16'd0}
  };

  acceleration_motion_detector i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .accel_x_i        (accel_x),
    .accel_y_i        (accel_y),
    .accel_z_i        (accel_z),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .change_level_o   (change_level),
    .motion_active_o  (motion_active),
    .baseline_valid_o (baseline_valid),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] floor_root(longint unsigned n);
    logic [15:0] root;
    longint unsigned trial;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = longint'(root) | (64'd1 << b);
      if (trial * trial <= n) begin
        root = trial[15:0];
      end
    end
    return root;
  endfunction

  function automatic detector_result_t advance_detector(accel_sample_t s);
    detector_result_t res;
    int unsigned mag, change, need, w;
    longint unsigned acc;
    res = IDLE_RES;
    mag = floor_root(longint'(s.x) * s.x + longint'(s.y) * s.y + longint'(s.z) * s.z);
    if (!rest_ready) begin
      rest_sum = rest_sum + 24'(mag);
      rest_count = rest_count + 8'd1;
      if (rest_count == BASELINE_SAMPLES) begin
        rest_level = 16'(rest_sum / BASELINE_SAMPLES);
        rest_ready = 1'b1;
      end
    end else begin
      change = (mag >= rest_level) ? mag - rest_level : rest_level - mag;
      need = (confirm_need == 0) ? 1 : confirm_need;
      w = (old_weight > 256) ? 256 : old_weight;
      if (change >= thresh) begin
        above_run = 8'((above_run + 1 < need) ? above_run + 1 : need);
        if (above_run >= need) begin
          moving = 1'b1;
        end
      end else begin
        above_run = '0;
      end
      if (!smooth_primed) begin
        smooth_level = 24'(change << 8);
        smooth_primed = 1'b1;
      end else begin
        acc = longint'(w) * smooth_level + longint'(256 - w) * (longint'(change) << 8) + 128;
        smooth_level = 24'(acc >> 8);
      end
      if (moving && change < thresh && smooth_level < {thresh, 8'd0}) begin
        moving = 1'b0;
      end
      if (moving) begin
        res.level = smooth_level[23:8];
      end
    end
    res.motion = moving;
    res.ready = rest_ready;
    return res;
  endfunction

  function automatic accel_sample_t shape_sample(int target);
    accel_sample_t s;
    int v;
    v = (target < 0) ? 0 : (target > 32767) ? 32767 : target;
    if ($urandom_range(0, 1)) begin
      v = -v;
    end
    s.x = ACCEL_W'(int'($urandom_range(0, 40)) - 20);
    s.y = ACCEL_W'(int'($urandom_range(0, 40)) - 20);
    s.z = ACCEL_W'(int'($urandom_range(0, 40)) - 20);
    case ($urandom_range(0, 2))
      0: s.x = ACCEL_W'(v);
      1: s.y = ACCEL_W'(v);
      default: s.z = ACCEL_W'(v);
    endcase
    return s;
  endfunction

  task automatic offer_sample(accel_sample_t s, logic typed, detector_result_t typed_res);
    detector_result_t predicted;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    accel_x <= s.x;
    accel_y <= s.y;
    accel_z <= s.z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_detector(s);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DEADBAND: thresh = data;
      CFG_CONFIRM:  confirm_need = data[7:0];
      CFG_WEIGHT:   old_weight = data[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_random(int count);
    int sent, quiet_len, move_len, need, sgn, target, base, band;
    sample_shape_e shape;
    accel_sample_t s;
    sent = 0;
    while (sent < count) begin
      base = rest_level;
      band = thresh;
      need = (confirm_need == 0) ? 1 : (confirm_need > 10) ? 10 : confirm_need;
      quiet_len = $urandom_range(1, 8);
      move_len = $urandom_range(1, need + 3);
      for (int i = 0; i < quiet_len + move_len && sent < count; i++) begin
        sgn = $urandom_range(0, 1) ? 1 : -1;
        case ($urandom_range(0, 7))
          0: shape = SHAPE_NOISE;
          1: shape = SHAPE_EDGE;
          default: shape = (i < quiet_len) ? SHAPE_QUIET : SHAPE_MOVE;
        endcase
        case (shape)
          SHAPE_NOISE: begin
            s.x = ACCEL_W'($urandom());
            s.y = ACCEL_W'($urandom());
            s.z = ACCEL_W'($urandom());
          end
          SHAPE_EDGE: begin
            target = base + sgn * (band + int'($urandom_range(0, 2)) - 1);
            s = shape_sample(target);
          end
          SHAPE_QUIET: begin
            target = base + sgn * int'($urandom_range(0, band / 2));
            s = shape_sample(target);
          end
          default: begin
            target = base + sgn * (band + int'($urandom_range(0, 6000)));
            s = shape_sample(target);
          end
        endcase
        offer_sample(s, 1'b0, IDLE_RES);
        sent++;
      end
    end
  endtask

  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    detector_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{change_level, motion_active, baseline_valid};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result: level %0d motion %0b baseline %0b",
                   got.level, got.motion, got.ready);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.level !== want.level || got.motion !== want.motion ||
            got.ready !== want.ready) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected level %0d motion %0b baseline %0b, got %0d %0b %0b",
                     want.level, want.motion, want.ready, got.level, got.motion, got.ready);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed_rows[i]) begin
      offer_sample(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].result);
    end
    run_random(35);
    drain_results();
    phases[5] = '{CFG_DATA_W'($urandom_range(0, 3000)), CFG_DATA_W'($urandom_range(0, 10)),
                  CFG_DATA_W'($urandom_range(0, 511))};
    phases[6] = '{CFG_DATA_W'($urandom_range(0, 3000)), CFG_DATA_W'($urandom_range(0, 10)),
                  CFG_DATA_W'($urandom_range(0, 511))};
    foreach (phases[p]) begin
      write_register(CFG_DEADBAND, phases[p].band);
      write_register(CFG_CONFIRM, phases[p].confirm);
      write_register(CFG_WEIGHT, phases[p].weight);
      if (p == 2) begin
        write_register(CFG_UNUSED, CFG_DATA_W'($urandom()));
      end
      if (p == 3) begin
        hold_request = 1'b1;
        calm = 1'b1;
        repeat (12) offer_sample(shape_sample(rest_level + 3000), 1'b0, IDLE_RES);
        calm = 1'b0;
      end
      if (p == 6) begin
        calm = 1'b1;
      end
      run_random(PHASE_ITEMS);
      drain_results();
    end
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
